FILE: rtl/core/grpe_pkg.sv
// Shared types, constants and helpers of the glyph row pixel expander.
package grpe_pkg;

    localparam int GLYPH_W = 8;
    localparam int GIDX_W  = $clog2(GLYPH_W);
    localparam int COORD_W = 11;
    localparam int POS_W   = 12;
    localparam int BASE_W  = 14;
    localparam int COL_N   = 2 * GLYPH_W;
    localparam int COL_W   = $clog2(COL_N);
    localparam int COLOR_W = 32;
    localparam int ADDR_W  = 20;
    localparam int SCALE_W = 2;
    localparam int CFG_W   = 11;
    localparam int CIDX_W  = 3;
    localparam int PROD_W  = 2 * COORD_W;

    localparam logic [COORD_W-1:0] RST_CLIP_RIGHT  = COORD_W'(1024);
    localparam logic [COORD_W-1:0] RST_CLIP_BOTTOM = COORD_W'(1024);
    localparam logic [COORD_W-1:0] RST_FRAME_WIDTH = COORD_W'(1024);

    typedef enum logic [CIDX_W-1:0] {
        REG_CLIP_LEFT    = 3'd0,
        REG_CLIP_TOP     = 3'd1,
        REG_CLIP_RIGHT   = 3'd2,
        REG_CLIP_BOTTOM  = 3'd3,
        REG_PIXEL_WIDTH  = 3'd4,
        REG_PIXEL_HEIGHT = 3'd5,
        REG_TRANSPARENT  = 3'd6,
        REG_FRAME_WIDTH  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic        [GLYPH_W-1:0] row_bits;
        logic signed [POS_W-1:0]   pos_x;
        logic signed [POS_W-1:0]   pos_y;
        logic        [COLOR_W-1:0] fg_color;
        logic        [COLOR_W-1:0] bg_color;
    } t_in;

    typedef struct packed {
        logic [ADDR_W-1:0]  write_addr;
        logic [COLOR_W-1:0] write_color;
        logic               last;
    } t_out;

    typedef struct packed {
        logic [COORD_W-1:0] clip_left;
        logic [COORD_W-1:0] clip_top;
        logic [COORD_W-1:0] clip_right;
        logic [COORD_W-1:0] clip_bottom;
        logic [SCALE_W-1:0] pixel_width;
        logic [SCALE_W-1:0] pixel_height;
        logic               transparent;
        logic [COORD_W-1:0] frame_width;
    } t_cfg;

    // One classified glyph row, handed from front to back.
    typedef struct packed {
        logic        [GLYPH_W-1:0] row_bits;
        logic        [COLOR_W-1:0] fg_color;
        logic        [COLOR_W-1:0] bg_color;
        logic signed [BASE_W-1:0]  bx0;
        logic signed [BASE_W-1:0]  by0;
        logic        [COL_N-1:0]   xmask;
        logic        [1:0]         ymask;
        logic        [GLYPH_W-1:0] any;
        logic        [GIDX_W-1:0]  i_last;
        logic                      iy_last;
        logic                      ix_last;
    } t_job;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    function automatic logic [GIDX_W-1:0] first_set(input logic [GLYPH_W-1:0] m);
        logic [GIDX_W-1:0] r;
        r = '0;
        for (int k = GLYPH_W - 1; k >= 0; k--) begin
            if (m[k]) r = GIDX_W'(k);
        end
        return r;
    endfunction

    function automatic logic [GIDX_W-1:0] last_set(input logic [GLYPH_W-1:0] m);
        logic [GIDX_W-1:0] r;
        r = '0;
        for (int k = 0; k < GLYPH_W; k++) begin
            if (m[k]) r = GIDX_W'(k);
        end
        return r;
    endfunction

    // Effective scale of 2 for register values 2 and 3; 0 and 1 act as 1.
    function automatic logic scale2(input logic [SCALE_W-1:0] s);
        return s[1];
    endfunction

endpackage

FILE: rtl/core/grpe_front.sv
// Front end: takes glyph rows, computes block origins and clip masks.
module grpe_front import grpe_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    input  logic i_q_full,
    output logic o_push,
    output t_job o_job
);

    logic                      r_a_valid;
    logic        [GLYPH_W-1:0] r_bits;
    logic        [COLOR_W-1:0] r_fg;
    logic        [COLOR_W-1:0] r_bg;
    logic signed [BASE_W-1:0]  r_bx0;
    logic signed [BASE_W-1:0]  r_by0;

    logic signed [BASE_W-1:0]  gx, gy, n_bx0, n_by0;
    logic signed [BASE_W-1:0]  clip_l, clip_r, clip_t, clip_b, xc, yc;
    logic                      pw2, ph2;
    logic        [COL_N-1:0]   xm;
    logic        [1:0]         ym;
    logic        [GLYPH_W-1:0] any;
    logic                      colany;

    assign pw2 = scale2(i_cfg.pixel_width);
    assign ph2 = scale2(i_cfg.pixel_height);

    assign o_in_ready = !r_a_valid || !i_q_full;

    // Stage A: scaled block origin of glyph pixel 0.
    always_comb begin
        gx     = BASE_W'(i_in_data.pos_x);
        gy     = BASE_W'(i_in_data.pos_y);
        clip_l = signed'({3'b000, i_cfg.clip_left});
        clip_t = signed'({3'b000, i_cfg.clip_top});
        n_bx0  = (pw2 ? (gx <<< 1) : gx) + clip_l;
        n_by0  = (ph2 ? (gy <<< 1) : gy) + clip_t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_bits <= i_in_data.row_bits;
            r_fg   <= i_in_data.fg_color;
            r_bg   <= i_in_data.bg_color;
            r_bx0  <= n_bx0;
            r_by0  <= n_by0;
        end
    end

    // Stage B: which screen columns and rows survive the clip test.
    always_comb begin
        clip_r = signed'({3'b000, i_cfg.clip_right});
        clip_b = signed'({3'b000, i_cfg.clip_bottom});
        for (int c = 0; c < COL_N; c++) begin
            xc    = r_bx0 + signed'(BASE_W'(c));
            xm[c] = (xc >= clip_l) && (xc < clip_r) && (pw2 || (c < GLYPH_W));
        end
        for (int k = 0; k < 2; k++) begin
            yc    = r_by0 + signed'(BASE_W'(k));
            ym[k] = (yc >= clip_t) && (yc < clip_b) && (ph2 || (k == 0));
        end
        for (int i = 0; i < GLYPH_W; i++) begin
            colany = pw2 ? (xm[2*i] || xm[2*i+1]) : xm[i];
            any[i] = (r_bits[GLYPH_W-1-i] || !i_cfg.transparent) && colany && (|ym);
        end
    end

    always_comb begin
        o_job.row_bits = r_bits;
        o_job.fg_color = r_fg;
        o_job.bg_color = r_bg;
        o_job.bx0      = r_bx0;
        o_job.by0      = r_by0;
        o_job.xmask    = xm;
        o_job.ymask    = ym;
        o_job.any      = any;
        o_job.i_last   = last_set(any);
        o_job.iy_last  = ym[1];
        o_job.ix_last  = pw2 && xm[{last_set(any), 1'b1}];
    end

    // Rows with nothing visible are dropped here.
    assign o_push = r_a_valid && !i_q_full && (|any);

endmodule

FILE: rtl/core/grpe_queue.sv
// Two-entry job queue between front and back.
module grpe_queue import grpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_job        = r_mem[r_rp];
    assign o_stat.valid = (r_cnt != 2'd0);
    assign o_stat.full  = (r_cnt == 2'd2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop)  r_rp <= !r_rp;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 2'd1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

FILE: rtl/core/grpe_back.sv
// Back end: walks the visible glyph pixels, one screen pixel a cycle while the output does not stall.
module grpe_back import grpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_q_stat i_q_stat,
    input  t_job    i_job,
    output logic    o_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out_data
);

    logic                r_busy;
    t_job                r_job;
    logic [GIDX_W-1:0]   r_i;
    logic                r_iy, r_ix;
    logic                n_busy;
    logic [GIDX_W-1:0]   n_i;
    logic                n_iy, n_ix;

    logic                r_g_valid;
    logic [COORD_W-1:0]  r_g_px, r_g_py;
    logic [COLOR_W-1:0]  r_g_color;
    logic                r_g_last;

    logic                r_o_valid;
    t_out                r_o_data;

    logic                pw2, ph2, o_load, g_free, step, surv, ix_end, iy_end, fin, has_next;
    logic [COL_W-1:0]    c;
    logic [GLYPH_W-1:0]  higher;
    logic [GIDX_W-1:0]   next_i;
    logic signed [BASE_W-1:0] px, py;
    logic [PROD_W-1:0]   row_base, addr_sum;

    assign pw2 = scale2(i_cfg.pixel_width);
    assign ph2 = scale2(i_cfg.pixel_height);

    assign o_load = r_g_valid && (!r_o_valid || i_out_ready);
    assign g_free = !r_g_valid || o_load;
    assign step   = r_busy && g_free;

    always_comb begin
        c        = pw2 ? {r_i, r_ix} : {1'b0, r_i};
        surv     = r_job.xmask[c] && r_job.ymask[r_iy];
        higher   = r_job.any & ~((GLYPH_W'(2) << r_i) - GLYPH_W'(1));
        has_next = |higher;
        next_i   = first_set(higher);
        ix_end   = !pw2 || r_ix;
        iy_end   = !ph2 || r_iy;
        fin      = ix_end && iy_end && !has_next;
        o_pop    = i_q_stat.valid && (!r_busy || (step && fin));
        px       = r_job.bx0 + signed'(BASE_W'(c));
        py       = r_job.by0 + signed'(BASE_W'(r_iy));

        n_busy = r_busy;
        n_i    = r_i;
        n_iy   = r_iy;
        n_ix   = r_ix;
        if (step) begin
            if (!ix_end) begin
                n_ix = 1'b1;
            end else begin
                n_ix = 1'b0;
                if (!iy_end) begin
                    n_iy = 1'b1;
                end else begin
                    n_iy = 1'b0;
                    n_i  = next_i;
                end
            end
            if (fin) n_busy = 1'b0;
        end
        if (o_pop) begin
            n_busy = 1'b1;
            n_i    = first_set(i_job.any);
            n_iy   = 1'b0;
            n_ix   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i  <= n_i;
        r_iy <= n_iy;
        r_ix <= n_ix;
        if (o_pop) r_job <= i_job;
    end

    // Candidate pixel stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
        end else if (g_free) begin
            r_g_valid <= step && surv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_g_px    <= px[COORD_W-1:0];
            r_g_py    <= py[COORD_W-1:0];
            r_g_color <= r_job.row_bits[GIDX_W'(GLYPH_W - 1) - r_i] ?
                         r_job.fg_color : r_job.bg_color;
            r_g_last  <= (r_i == r_job.i_last) && (r_iy == r_job.iy_last) &&
                         (r_ix == r_job.ix_last);
        end
    end

    // Output register: linear address from row and column.
    always_comb begin
        row_base = r_g_py * i_cfg.frame_width;
        addr_sum = row_base + PROD_W'(r_g_px);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || i_out_ready) begin
            r_o_valid <= r_g_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_o_data.write_addr  <= addr_sum[ADDR_W-1:0];
            r_o_data.write_color <= r_g_color;
            r_o_data.last        <= r_g_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

endmodule

FILE: rtl/core/glyph_row_pixel_expander_unit.sv
// Top level of the glyph row pixel expander: config registers and block wiring.
//
// Usage: one input beat on i_in_* carries a glyph row (bit 7 leftmost), a
// signed glyph position and foreground/background colors. Each visible screen
// pixel of the row becomes one output beat on o_out_* with its linear
// frame-buffer address and color; last marks the final beat of the row.
// Rows with no visible pixel produce no output beat.
// Registers are written through i_cfg_we/i_cfg_idx/i_cfg_data. The user must
// write them only while idle; the block itself does not enforce this. A row
// passes the stage A register, the job queue, the walker, the candidate pixel
// register and the output register. The walker steps one screen pixel per cycle
// while the receiver does not stall, over each screen pixel of every glyph pixel
// with a visible part, clipped ones too, and uses a single address multiplier.
// The front end keeps accepting rows into a two-entry queue while the back
// end works; a stalled receiver holds the output register and backs up the
// walker, then the queue, then the front stage, and o_in_ready drops.
// Reset (synchronous, active low) empties all stages and loads the register
// defaults: full 1024x1024 clip, scale 1, opaque, frame width 1024.
module glyph_row_pixel_expander_unit import grpe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out              o_out_data,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg    r_cfg;
    t_job    front_job, q_job;
    t_q_stat q_stat;
    logic    q_push, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_left    <= '0;
            r_cfg.clip_top     <= '0;
            r_cfg.clip_right   <= RST_CLIP_RIGHT;
            r_cfg.clip_bottom  <= RST_CLIP_BOTTOM;
            r_cfg.pixel_width  <= SCALE_W'(1);
            r_cfg.pixel_height <= SCALE_W'(1);
            r_cfg.transparent  <= 1'b0;
            r_cfg.frame_width  <= RST_FRAME_WIDTH;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLIP_LEFT:    r_cfg.clip_left    <= i_cfg_data[COORD_W-1:0];
                REG_CLIP_TOP:     r_cfg.clip_top     <= i_cfg_data[COORD_W-1:0];
                REG_CLIP_RIGHT:   r_cfg.clip_right   <= i_cfg_data[COORD_W-1:0];
                REG_CLIP_BOTTOM:  r_cfg.clip_bottom  <= i_cfg_data[COORD_W-1:0];
                REG_PIXEL_WIDTH:  r_cfg.pixel_width  <= i_cfg_data[SCALE_W-1:0];
                REG_PIXEL_HEIGHT: r_cfg.pixel_height <= i_cfg_data[SCALE_W-1:0];
                REG_TRANSPARENT:  r_cfg.transparent  <= i_cfg_data[0];
                REG_FRAME_WIDTH:  r_cfg.frame_width  <= i_cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    grpe_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_full   (q_stat.full),
        .o_push     (q_push),
        .o_job      (front_job)
    );

    grpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    grpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_stat    (q_stat),
        .i_job       (q_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_stat.valid)
        else $error("job queue read while empty");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> q_stat.full)
        else $error("input stalled with room in the job queue");

endmodule

FILE: verif/tb_glyph_row_pixel_expander_unit.sv
// Self-checking testbench for glyph_row_pixel_expander_unit: glyph rows in, predicted writes out.
module tb_glyph_row_pixel_expander_unit;
    import grpe_pkg::*;

    class row_write_predictor;
        t_cfg cfg;
        t_out pending_writes[$];
        int   mismatches;

        function new();
            cfg.clip_left    = '0;
            cfg.clip_top     = '0;
            cfg.clip_right   = RST_CLIP_RIGHT;
            cfg.clip_bottom  = RST_CLIP_BOTTOM;
            cfg.pixel_width  = SCALE_W'(1);
            cfg.pixel_height = SCALE_W'(1);
            cfg.transparent  = 1'b0;
            cfg.frame_width  = RST_FRAME_WIDTH;
            mismatches       = 0;
        endfunction

        // 0 acts as 1, 3 acts as 2
        function int scale_of(logic [SCALE_W-1:0] s);
            if (s == 0) return 1;
            if (s > 2) return 2;
            return int'(s);
        endfunction

        function void set_reg(t_reg_idx idx, int val);
            case (idx)
                REG_CLIP_LEFT:    cfg.clip_left    = COORD_W'(val);
                REG_CLIP_TOP:     cfg.clip_top     = COORD_W'(val);
                REG_CLIP_RIGHT:   cfg.clip_right   = COORD_W'(val);
                REG_CLIP_BOTTOM:  cfg.clip_bottom  = COORD_W'(val);
                REG_PIXEL_WIDTH:  cfg.pixel_width  = SCALE_W'(val);
                REG_PIXEL_HEIGHT: cfg.pixel_height = SCALE_W'(val);
                REG_TRANSPARENT:  cfg.transparent  = val[0];
                REG_FRAME_WIDTH:  cfg.frame_width  = COORD_W'(val);
                default: ;
            endcase
        endfunction

        // Queue every visible screen pixel of an accepted row, in output order.
        function void expand_row(t_in row);
            int pw, ph, gx, gy, bx, by, px, py, start;
            int cl, ct, cr, cb;
            logic [31:0] color, addr;
            logic lit;
            t_out w;
            start = pending_writes.size();
            pw = scale_of(cfg.pixel_width);
            ph = scale_of(cfg.pixel_height);
            gx = $signed(row.pos_x);
            gy = $signed(row.pos_y);
            cl = int'(cfg.clip_left);
            ct = int'(cfg.clip_top);
            cr = int'(cfg.clip_right);
            cb = int'(cfg.clip_bottom);
            for (int i = 0; i < GLYPH_W; i++) begin
                lit = row.row_bits[GLYPH_W-1-i];
                if (!lit && cfg.transparent) continue;
                color = lit ? row.fg_color : row.bg_color;
                bx = (gx + i) * pw + cl;
                by = gy * ph + ct;
                for (int iy = 0; iy < ph; iy++) begin
                    for (int ix = 0; ix < pw; ix++) begin
                        px = bx + ix;
                        py = by + iy;
                        if (px >= cl && py >= ct && px < cr && py < cb) begin
                            addr = 32'(py) * 32'(cfg.frame_width) + 32'(px);
                            w.write_addr  = addr[ADDR_W-1:0];
                            w.write_color = color;
                            w.last        = 1'b0;
                            pending_writes.insert(pending_writes.size(), w);
                        end
                    end
                end
            end
            if (pending_writes.size() > start)
                pending_writes[pending_writes.size()-1].last = 1'b1;
        endfunction

        task report(string msg);
            mismatches++;
            $display("mismatch: %s", msg);
        endtask

        task check_write(t_out got);
            t_out want;
            if (pending_writes.size() == 0) begin
                report($sformatf("unexpected write addr=%0h color=%0h last=%0b",
                                 got.write_addr, got.write_color, got.last));
                return;
            end
            want = pending_writes.pop_front();
            if (got.write_addr !== want.write_addr)
                report($sformatf("write_addr got %0h want %0h",
                                 got.write_addr, want.write_addr));
            if (got.write_color !== want.write_color)
                report($sformatf("write_color got %0h want %0h (addr %0h)",
                                 got.write_color, want.write_color, want.write_addr));
            if (got.last !== want.last)
                report($sformatf("last got %0b want %0b (addr %0h)",
                                 got.last, want.last, want.write_addr));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               row_valid;
    logic               row_ready;
    t_in                row_beat;
    logic               wr_valid;
    logic               wr_ready;
    t_out               wr_beat;
    logic               cfg_we;
    logic [CIDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]   cfg_data;

    row_write_predictor model;
    int src_idle_pct;
    int sink_stall_pct;
    int hold_left;

    glyph_row_pixel_expander_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (row_valid),
        .o_in_ready  (row_ready),
        .i_in_data   (row_beat),
        .o_out_valid (wr_valid),
        .i_out_ready (wr_ready),
        .o_out_data  (wr_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Write-side back-pressure; a nonzero hold_left forces a long stall.
    initial begin
        wr_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                wr_ready = 1'b0;
                hold_left--;
            end else begin
                wr_ready = ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && wr_valid && wr_ready) model.check_write(wr_beat);
    end

    function automatic t_in make_row(logic [7:0] bits, int px, int py,
                                     logic [31:0] fg, logic [31:0] bg);
        t_in r;
        r.row_bits = bits;
        r.pos_x    = px[POS_W-1:0];
        r.pos_y    = py[POS_W-1:0];
        r.fg_color = fg;
        r.bg_color = bg;
        return r;
    endfunction

    function automatic int clamp_pos(int v);
        if (v < -2048) return -2048;
        if (v > 2047) return 2047;
        return v;
    endfunction

    // Positions cluster on the clip edges; a few land anywhere in the field.
    function automatic t_in random_row();
        int xs, ys, px, py, r;
        xs = int'(model.cfg.clip_right) - int'(model.cfg.clip_left);
        ys = int'(model.cfg.clip_bottom) - int'(model.cfg.clip_top);
        if (xs < 0) xs = 0;
        if (ys < 0) ys = 0;
        xs = xs / model.scale_of(model.cfg.pixel_width);
        ys = ys / model.scale_of(model.cfg.pixel_height);
        r = $urandom_range(99);
        if (r < 12)      px = int'($urandom_range(4095)) - 2048;
        else if (r < 40) px = int'($urandom_range(10)) - 9;
        else if (r < 65) px = xs - 8 + int'($urandom_range(10));
        else             px = int'($urandom_range(xs));
        r = $urandom_range(99);
        if (r < 12)      py = int'($urandom_range(4095)) - 2048;
        else if (r < 40) py = int'($urandom_range(4)) - 2;
        else if (r < 65) py = ys - 2 + int'($urandom_range(4));
        else             py = int'($urandom_range(ys));
        return make_row(8'($urandom()), clamp_pos(px), clamp_pos(py), $urandom(), $urandom());
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_row(t_in row);
        while ($urandom_range(99) < src_idle_pct) begin
            row_valid = 1'b0;
            @(negedge clk);
        end
        row_beat  = row;
        row_valid = 1'b1;
        do @(posedge clk); while (!row_ready);
        model.expand_row(row);
        @(negedge clk);
    endtask

    task automatic wait_writes_done();
        row_valid = 1'b0;
        while (model.pending_writes.size() != 0) @(negedge clk);
    endtask

    task automatic write_reg(t_reg_idx idx, int val);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = CFG_W'(val);
        @(negedge clk);
        cfg_we   = 1'b0;
        model.set_reg(idx, val);
    endtask

    initial begin
        int setups[8][8];
        int idle_modes[4][2];
        int n_rows;
        bit empty_clip;

        setups = '{
            '{0,    0,    1024, 1024, 1, 1, 0, 1024},
            '{100,  50,   140,  60,   2, 2, 1, 640},
            '{0,    0,    2047, 2047, 3, 0, 0, 2047},
            '{500,  300,  400,  700,  2, 2, 0, 0},
            '{7,    3,    50,   20,   0, 3, 1, 0},
            '{1000, 1000, 1024, 1024, 2, 1, 0, 1},
            '{0,    1020, 2047, 2047, 2, 2, 0, 1024},
            '{3,    5,    1024, 1024, 1, 2, 1, 1000}
        };
        idle_modes = '{'{0, 0}, '{78, 0}, '{0, 78}, '{13, 13}};
        model          = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_left      = 0;
        rst_n          = 1'b0;
        row_valid      = 1'b0;
        row_beat       = '0;
        cfg_we         = 1'b0;
        cfg_idx        = '0;
        cfg_data       = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset configuration: full 1024x1024 clip, scale 1, opaque
        send_row(make_row(8'hFF, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555));
        send_row(make_row(8'h00, 1, 1, 32'h0000_0000, 32'hFFFF_FFFF));
        send_row(make_row(8'h81, -1, 2, 32'h1234_5678, 32'h9ABC_DEF0));
        send_row(make_row(8'hA5, 1020, 1023, 32'hFFFF_FFFF, 32'h0000_0000));
        send_row(make_row(8'h3C, 0, 1024, 32'h0F0F_0F0F, 32'hF0F0_F0F0));
        send_row(make_row(8'hFF, -8, 0, 32'h1111_1111, 32'h2222_2222));
        send_row(make_row(8'hFF, -2048, -2048, 32'h3333_3333, 32'h4444_4444));
        send_row(make_row(8'hFF, 2047, 2047, 32'h6666_6666, 32'h7777_7777));
        send_row(make_row(8'h01, -7, 5, 32'h8888_8888, 32'h9999_9999));
        send_row(make_row(8'h80, 1023, 0, 32'hCCCC_CCCC, 32'hDDDD_DDDD));
        send_row(make_row(8'h55, 1016, 1023, 32'hFFFF_FFFF, 32'h0000_0000));

        for (int p = 0; p < 8; p++) begin
            // registers change only with the block drained; rows with no
            // visible pixel may still be in flight, hence the extra wait
            wait_writes_done();
            repeat (64) @(negedge clk);
            write_reg(REG_CLIP_LEFT,    setups[p][0]);
            write_reg(REG_CLIP_TOP,     setups[p][1]);
            write_reg(REG_CLIP_RIGHT,   setups[p][2]);
            write_reg(REG_CLIP_BOTTOM,  setups[p][3]);
            write_reg(REG_PIXEL_WIDTH,  setups[p][4]);
            write_reg(REG_PIXEL_HEIGHT, setups[p][5]);
            write_reg(REG_TRANSPARENT,  setups[p][6]);
            write_reg(REG_FRAME_WIDTH,  setups[p][7]);
            src_idle_pct   = idle_modes[p % 4][0];
            sink_stall_pct = idle_modes[p % 4][1];
            // long receiver stall while rows keep coming: fills the queue
            if (p == 0) hold_left = 400;
            empty_clip = (setups[p][2] <= setups[p][0]) || (setups[p][3] <= setups[p][1]);
            n_rows = empty_clip ? 12 : 64;
            send_row(make_row(8'hC3, 0, 0, 32'h0000_FFFF, 32'hFFFF_0000));
            for (int k = 0; k < n_rows; k++) begin
                if (k == 32) wait_writes_done();
                send_row(random_row());
            end
        end

        wait_writes_done();
        repeat (50) @(negedge clk);
        if (model.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

FILE: filelist.f
rtl/core/grpe_pkg.sv
rtl/core/grpe_front.sv
rtl/core/grpe_queue.sv
rtl/core/grpe_back.sv
rtl/core/glyph_row_pixel_expander_unit.sv
verif/tb_glyph_row_pixel_expander_unit.sv
